FILE: sv/wrs_pkg.sv
package wrs_pkg;

    localparam int NSLOT = 8;
    localparam int TAG_W = 3;
    localparam int CNT_W = 4;
    localparam logic [15:0] MAX_CHUNK = 16'd32768;
    localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

    localparam logic [2:0] K_OPEN_OK  = 3'd0;
    localparam logic [2:0] K_OPEN_BAD = 3'd1;
    localparam logic [2:0] K_READ     = 3'd2;
    localparam logic [2:0] K_CLOSE    = 3'd3;
    localparam logic [2:0] K_CANCEL   = 3'd4;

    localparam logic [2:0] C_DATA  = 3'd0;
    localparam logic [2:0] C_EOF   = 3'd2;
    localparam logic [2:0] C_ERROR = 3'd3;

    localparam logic [1:0] O_READ     = 2'd0;
    localparam logic [1:0] O_CLOSE    = 2'd1;
    localparam logic [1:0] O_PROGRESS = 2'd2;
    localparam logic [1:0] O_FINISH   = 2'd3;

    localparam logic [1:0] F_RUN    = 2'd0;
    localparam logic [1:0] F_DONE   = 2'd1;
    localparam logic [1:0] F_FAILED = 2'd2;
    localparam logic [1:0] F_CANCEL = 2'd3;

    localparam logic CFG_TOTAL = 1'b0;
    localparam logic CFG_CHUNK = 1'b1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  resp_tag;
        logic [2:0]  resp_class;
        logic [31:0] data_length;
        logic        local_write_failed;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [2:0]  req_tag;
        logic [63:0] req_offset;
        logic [15:0] req_length;
        logic [63:0] bytes_done;
        logic [1:0]  final_state;
        logic        last;
    } out_word_t;

endpackage

FILE: sv/wrs_fifo.sv
module wrs_fifo
    import wrs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_word_t push_data,
    output logic     full,
    input  logic     pop,
    output in_word_t pop_data,
    output logic     empty
);

    in_word_t   mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign full     = cnt_reg == 2'd2;
    assign empty    = cnt_reg == 2'd0;
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: sv/wrs_engine.sv
module wrs_engine
    import wrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        q_empty,
    input  in_word_t    q_data,
    output logic        q_pop,
    output logic        out_valid,
    output out_word_t   out_word,
    input  logic        out_stall
);

    typedef enum logic [1:0] {
        S_IDLE, S_PUMP, S_CHK, S_LAST
    } state_t;

    state_t      state_reg;
    logic [63:0] total_reg;
    logic [15:0] chunk_reg;
    logic [63:0] next_pos_reg;
    logic [63:0] eof_off_reg;
    logic        eof_seen_reg;
    logic [CNT_W-1:0] infl_reg;
    logic [NSLOT-1:0] busy_reg;
    logic [CNT_W-1:0] rcnt_reg;
    logic [63:0] bytes_reg;
    logic        failed_reg;
    logic        canc_reg;
    logic        fin_reg;
    logic        closing_reg;
    logic        cdone_reg;
    logic        open_reg;
    logic        ov_reg;
    out_word_t   ow_reg;
    out_word_t   pend_reg;
    logic        pend_v_reg;

    logic [63:0] soff_mem [NSLOT];
    logic [15:0] slen_mem [NSLOT];
    logic [63:0] roff_mem [NSLOT];
    logic [15:0] rlen_mem [NSLOT];

    logic [15:0] chunk_eff;
    logic [63:0] limit;
    logic [63:0] room;
    logic [TAG_W-1:0] free_tag;
    logic        has_free;
    logic [TAG_W-1:0] rtop;
    logic        can_issue;
    logic        xfer_done;
    logic        fin_cond;
    logic [1:0]  fin_code;
    logic        close_go;
    logic        finish_go;
    logic        out_free;
    logic        park_ok;
    logic        issue;
    logic [63:0] iss_off;
    logic [15:0] iss_len;
    logic        ow_load;
    out_word_t   ow_src;
    logic        rd_hit;
    logic        data_ok;
    logic        retry_push;
    logic [63:0] bytes_new;

    in_word_t    w;
    logic [63:0] r_off;
    logic [15:0] r_len;
    logic [15:0] n;
    logic [63:0] eof_min;

    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign out_valid = ov_reg;
    assign out_word  = ow_reg;
    assign w         = q_data;
    assign r_off     = soff_mem[w.resp_tag];
    assign r_len     = slen_mem[w.resp_tag];
    assign n         = (w.data_length > {16'd0, r_len}) ? r_len : w.data_length[15:0];
    assign eof_min   = (r_off < eof_off_reg) ? r_off : eof_off_reg;
    assign rtop      = rcnt_reg[TAG_W-1:0] - 1'b1;

    always_comb
    begin
        chunk_eff = chunk_reg;
        if (chunk_reg == 16'd0)
        begin
            chunk_eff = 16'd1;
        end
        else if (chunk_reg > MAX_CHUNK)
        begin
            chunk_eff = MAX_CHUNK;
        end
        limit = eof_seen_reg ? eof_off_reg : ((total_reg != 64'd0) ? total_reg : ALL_ONES);
        room  = limit - next_pos_reg;
        free_tag = '0;
        has_free = 1'b0;
        for (int i = NSLOT - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_tag = TAG_W'(i);
                has_free = 1'b1;
            end
        end
        can_issue = !failed_reg && !canc_reg && open_reg && (infl_reg < CNT_W'(NSLOT))
                    && has_free && ((rcnt_reg != '0) || (next_pos_reg < limit));
        xfer_done = (rcnt_reg == '0) &&
                    (eof_seen_reg || ((total_reg != 64'd0) && (next_pos_reg >= total_reg)));
        fin_cond = !fin_reg && (infl_reg == '0) && (failed_reg || canc_reg || xfer_done);
        fin_code = failed_reg ? F_FAILED : (canc_reg ? F_CANCEL : F_DONE);
        close_go  = fin_cond && open_reg && !closing_reg;
        finish_go = fin_cond && !close_go && !(open_reg && !cdone_reg);

        out_free = !ov_reg || !out_stall;
        park_ok  = !pend_v_reg || out_free;
        issue    = (state_reg == S_PUMP) && can_issue && park_ok;
        if (rcnt_reg != '0)
        begin
            iss_off = roff_mem[rtop];
            iss_len = rlen_mem[rtop];
        end
        else
        begin
            iss_off = next_pos_reg;
            iss_len = (room < {48'd0, chunk_eff}) ? room[15:0] : chunk_eff;
        end

        ow_load = 1'b0;
        ow_src  = pend_reg;
        unique case (state_reg)
            S_PUMP: ow_load = issue && pend_v_reg;
            S_CHK:  ow_load = (close_go || finish_go) && pend_v_reg && out_free;
            S_LAST:
            begin
                ow_load     = pend_v_reg && out_free;
                ow_src.last = 1'b1;
            end
            default: ;
        endcase

        rd_hit  = (w.kind == K_READ) && busy_reg[w.resp_tag];
        data_ok = rd_hit && (w.resp_class == C_DATA) && !failed_reg && !canc_reg
                  && (n != 16'd0) && !w.local_write_failed;
        retry_push = data_ok && (n < r_len) && (rcnt_reg < CNT_W'(NSLOT));
        bytes_new  = data_ok ? bytes_reg + {48'd0, n} : bytes_reg;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            soff_mem[free_tag] <= iss_off;
            slen_mem[free_tag] <= iss_len;
        end
        if (q_pop && !fin_reg && retry_push)
        begin
            roff_mem[rcnt_reg[TAG_W-1:0]] <= r_off + {48'd0, n};
            rlen_mem[rcnt_reg[TAG_W-1:0]] <= r_len - n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            total_reg    <= 64'd0;
            chunk_reg    <= MAX_CHUNK;
            next_pos_reg <= 64'd0;
            eof_off_reg  <= ALL_ONES;
            eof_seen_reg <= 1'b0;
            infl_reg     <= '0;
            busy_reg     <= '0;
            rcnt_reg     <= '0;
            bytes_reg    <= 64'd0;
            failed_reg   <= 1'b0;
            canc_reg     <= 1'b0;
            fin_reg      <= 1'b0;
            closing_reg  <= 1'b0;
            cdone_reg    <= 1'b0;
            open_reg     <= 1'b0;
            ov_reg       <= 1'b0;
            ow_reg       <= '0;
            pend_reg     <= '0;
            pend_v_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TOTAL: total_reg <= cfg_data;
                    CFG_CHUNK: chunk_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (ow_load)
            begin
                ov_reg <= 1'b1;
                ow_reg <= ow_src;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop && !fin_reg)
                    begin
                        unique case (w.kind)
                            K_OPEN_OK:
                            begin
                                open_reg  <= 1'b1;
                                state_reg <= S_PUMP;
                            end
                            K_OPEN_BAD:
                            begin
                                failed_reg <= 1'b1;
                                pend_reg   <= '{O_PROGRESS, 3'd0, 64'd0, 16'd0, bytes_reg,
                                               F_RUN, 1'b0};
                                pend_v_reg <= 1'b1;
                                state_reg  <= S_CHK;
                            end
                            K_READ:
                            begin
                                if (rd_hit)
                                begin
                                    busy_reg[w.resp_tag] <= 1'b0;
                                    infl_reg  <= infl_reg - 1'b1;
                                    bytes_reg <= bytes_new;
                                    pend_reg  <= '{O_PROGRESS, 3'd0, 64'd0, 16'd0, bytes_new,
                                                   F_RUN, 1'b0};
                                    if (retry_push)
                                    begin
                                        rcnt_reg <= rcnt_reg + 1'b1;
                                    end
                                    if (w.resp_class == C_DATA)
                                    begin
                                        if (!failed_reg && !canc_reg)
                                        begin
                                            if (n == 16'd0)
                                            begin
                                                eof_seen_reg <= 1'b1;
                                                eof_off_reg  <= eof_min;
                                            end
                                            else if (w.local_write_failed)
                                            begin
                                                failed_reg <= 1'b1;
                                            end
                                        end
                                    end
                                    else if (w.resp_class == C_EOF)
                                    begin
                                        eof_seen_reg <= 1'b1;
                                        eof_off_reg  <= eof_min;
                                    end
                                    else if (w.resp_class == C_ERROR)
                                    begin
                                        if (!canc_reg)
                                        begin
                                            failed_reg <= 1'b1;
                                        end
                                    end
                                    pend_v_reg <= 1'b1;
                                    state_reg  <= S_PUMP;
                                end
                            end
                            K_CLOSE:
                            begin
                                if (closing_reg && !cdone_reg)
                                begin
                                    if ((w.resp_class == C_EOF || w.resp_class == C_ERROR)
                                        && !canc_reg)
                                    begin
                                        failed_reg <= 1'b1;
                                    end
                                    cdone_reg <= 1'b1;
                                    state_reg <= S_PUMP;
                                end
                            end
                            K_CANCEL:
                            begin
                                canc_reg  <= 1'b1;
                                state_reg <= S_CHK;
                            end
                            default: ;
                        endcase
                    end
                end
                S_PUMP:
                begin
                    if (!can_issue)
                    begin
                        state_reg <= S_CHK;
                    end
                    else if (park_ok)
                    begin
                        busy_reg[free_tag] <= 1'b1;
                        infl_reg   <= infl_reg + 1'b1;
                        pend_reg   <= '{O_READ, free_tag, iss_off, iss_len, bytes_reg,
                                        F_RUN, 1'b0};
                        pend_v_reg <= 1'b1;
                        if (rcnt_reg != '0)
                        begin
                            rcnt_reg <= rcnt_reg - 1'b1;
                        end
                        else
                        begin
                            next_pos_reg <= next_pos_reg + {48'd0, iss_len};
                        end
                    end
                end
                S_CHK:
                begin
                    if (close_go)
                    begin
                        if (park_ok)
                        begin
                            closing_reg <= 1'b1;
                            pend_reg    <= '{O_CLOSE, 3'd0, 64'd0, 16'd0, bytes_reg,
                                             F_RUN, 1'b0};
                            pend_v_reg  <= 1'b1;
                            state_reg   <= S_LAST;
                        end
                    end
                    else if (finish_go)
                    begin
                        if (park_ok)
                        begin
                            fin_reg    <= 1'b1;
                            pend_reg   <= '{O_FINISH, 3'd0, 64'd0, 16'd0, bytes_reg,
                                            fin_code, 1'b0};
                            pend_v_reg <= 1'b1;
                            state_reg  <= S_LAST;
                        end
                    end
                    else
                    begin
                        state_reg <= S_LAST;
                    end
                end
                S_LAST:
                begin
                    if (!pend_v_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        pend_v_reg <= 1'b0;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/windowed_read_scheduler.sv
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | in_word  (in_word_t)
// out     | out_valid | out_stall | out_word (out_word_t)
// cfg     | cfg_we    | -         | cfg_index, cfg_data
// A 2-deep queue takes input words; in_stall is high only while it is full.
// The engine handles one input at a time: it takes it, issues its read requests in
// the pump state, then ends the pump, checks close/finish and releases the last
// word; cancel and a refused open skip the pump. Each result is held in a park
// register before the output register; out_stall holds the engine only when park
// and output registers are both full. Slot and retry stores are unreset.
module windowed_read_scheduler
    import wrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_word,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_word,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    logic     q_full;
    logic     q_empty;
    logic     q_pop;
    in_word_t q_data;

    assign in_stall = q_full;

    wrs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !q_full),
        .push_data (in_word),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    wrs_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_word  (out_word),
        .out_stall (out_stall)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty) else $error("pop from empty queue");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid) else $error("output dropped");

    a_stall_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_word)) else $error("stalled word changed");

    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.out_kind == O_FINISH |-> out_word.last)
        else $error("finish not last");

endmodule
